FILE: rtl/assert_macros.svh
// Assertion macros used by the refresher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of aclk, outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks that a condition never holds on a rising edge of aclk, outside reset.
`define ASSERT_NEVER(name, cond, msg) \
    `ASSERT_CLK(name, !(cond), msg)

`endif

FILE: rtl/frc_pkg.sv
// Package with the types and constants of the LED chain frame refresher.
`default_nettype none

package frc_pkg;

    // Frame geometry.
    localparam int FRAME_W     = 192;
    localparam int FRAME_H     = 9;
    localparam int DIGIT_LINES = 8;

    // Default chain shape.
    localparam int DEFAULT_CHAIN_CHIPS  = 32;
    localparam int DEFAULT_CHIP_COLUMNS = 6;

    // Field widths.
    localparam int OP_W   = 2;
    localparam int X_W    = 8;
    localparam int Y_W    = 4;
    localparam int D_W    = 3;
    localparam int WORD_W = 16;
    localparam int ROW_AW = $clog2(FRAME_H);

    typedef logic [FRAME_W-1:0] row_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [ROW_AW-1:0]  row_addr_t;

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_REFRESH = 2'd1,
        OP_BCAST   = 2'd2
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_REF_RD8,
        ST_REF_RDR,
        ST_REF_LOAD,
        ST_SEND
    } state_t;

    // Controls from the sequencer to the row shift unit.
    typedef struct packed {
        logic load_top;
        logic load_row;
        logic shift;
        logic bcast;
    } shift_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/frc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module frc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/frc_shift.sv
// Row shift unit: holds the two frame rows of a refresh and forms one chain word a cycle while told to shift.
`default_nettype none

module frc_shift #(
    parameter int CHIP_COLUMNS = frc_pkg::DEFAULT_CHIP_COLUMNS
) (
    input  wire logic                      aclk,
    input  wire frc_pkg::shift_ctrl_t      ctrl,
    input  wire frc_pkg::row_t             row_data,
    input  wire logic [frc_pkg::D_W-1:0]   digit,
    input  wire frc_pkg::word_t            command,
    output frc_pkg::word_t                 word
);

    import frc_pkg::*;

    row_t             top_reg;
    row_t             row_reg;
    logic [X_W-1:0]   tap_idx;
    logic             top_bit;
    logic [7:0]       data_bits;
    logic [3:0]       addr_nib;

    // Row registers: loaded from the frame store, then shifted one chip a step.
    always_ff @(posedge aclk) begin
        if (ctrl.load_top) begin
            top_reg <= row_data;
        end else if (ctrl.shift) begin
            top_reg <= top_reg << CHIP_COLUMNS;
        end
        if (ctrl.load_row) begin
            row_reg <= row_data;
        end else if (ctrl.shift) begin
            row_reg <= row_reg << CHIP_COLUMNS;
        end
    end

    // The extra row-8 pixel sits d-2 columns below the current chip's top column.
    always_comb begin
        if (digit >= D_W'(2)) begin
            tap_idx = X_W'(FRAME_W + 1) - X_W'(digit);
        end else begin
            tap_idx = X_W'(FRAME_W - 1);
        end
        top_bit = (digit >= D_W'(2)) ? top_reg[tap_idx] : 1'b0;
    end

    // Word assembly: digit address in the high byte, pixel bits below; a broadcast passes the command word.
    always_comb begin
        data_bits = '0;
        data_bits[CHIP_COLUMNS-1:0] = row_reg[FRAME_W-1 -: CHIP_COLUMNS];
        data_bits[CHIP_COLUMNS] = top_bit;
        addr_nib = 4'(digit) + 4'd1;
        if (ctrl.bcast) begin
            word = command;
        end else begin
            word = {4'b0000, addr_nib, data_bits};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/led_chain_frame_refresher.sv
// Top level of the LED chain frame refresher: sequencer, frame store and output register.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | operation, pixel_x/y/on, digit_index, command_word
//  m_      | out       | m_valid / m_ready  | output_word, latch_after
//
// A pixel write passes through accept, row read and row write back, in that order.
// A refresh fetches rows 8 and 7-d in turn through the single read port of the frame store,
// loads them into the row shift unit, then sends CHAIN_CHIPS words, one per chip.
// A broadcast sends CHAIN_CHIPS copies of the command word; a stalled output stops the sequence.
// Reset clears nine row valid bits at once; no clearing pass is needed.
// The input is taken only in the idle state; the last word may still wait at the output.
`default_nettype none

module led_chain_frame_refresher #(
    parameter int CHAIN_CHIPS  = frc_pkg::DEFAULT_CHAIN_CHIPS,
    parameter int CHIP_COLUMNS = frc_pkg::DEFAULT_CHIP_COLUMNS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [frc_pkg::OP_W-1:0]    s_operation,
    input  wire logic [frc_pkg::X_W-1:0]     s_pixel_x,
    input  wire logic [frc_pkg::Y_W-1:0]     s_pixel_y,
    input  wire logic                        s_pixel_on,
    input  wire logic [frc_pkg::D_W-1:0]     s_digit_index,
    input  wire logic [frc_pkg::WORD_W-1:0]  s_command_word,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [frc_pkg::WORD_W-1:0]       m_output_word,
    output logic                             m_latch_after
);

    import frc_pkg::*;

    `include "assert_macros.svh"

    localparam int CHIP_W = (CHAIN_CHIPS > 1) ? $clog2(CHAIN_CHIPS) : 1;

    state_t              state_reg, state_next;
    logic [CHIP_W-1:0]   chip_reg, chip_next;
    logic [FRAME_H-1:0]  valid_reg, valid_next;
    row_addr_t           rd_row_reg;
    logic                m_valid_reg, m_valid_next;
    word_t               out_word_reg;
    logic                out_last_reg;
    logic                bcast_reg;

    logic [X_W-1:0]      x_reg;
    logic [Y_W-1:0]      y_reg;
    logic                on_reg;
    logic [D_W-1:0]      d_reg;
    word_t               cmd_reg;

    logic                accept;
    logic                out_load;
    logic                chip_last;
    shift_ctrl_t         ctrl;
    row_addr_t           raddr;
    row_addr_t           ref_row;
    logic                ram_we;
    row_t                ram_rdata;
    row_t                row_masked;
    row_t                row_wdata;
    word_t               unit_word;

    assign accept    = s_valid && s_ready;
    assign chip_last = (chip_reg == CHIP_W'(CHAIN_CHIPS - 1));
    assign ref_row   = row_addr_t'(DIGIT_LINES - 1) - row_addr_t'(d_reg);

    // Rows never written read as cleared.
    assign row_masked = valid_reg[rd_row_reg] ? ram_rdata : '0;

    // Read-modify-write data for a pixel write.
    always_comb begin
        row_wdata = row_masked;
        row_wdata[x_reg] = on_reg;
    end

    // Frame store: one frame row per entry.
    frc_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAME_H)
    ) u_frame (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (y_reg),
        .wdata (row_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Row shift unit forming the chain words.
    frc_shift #(
        .CHIP_COLUMNS (CHIP_COLUMNS)
    ) u_shift (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .row_data (row_masked),
        .digit    (d_reg),
        .command  (cmd_reg),
        .word     (unit_word)
    );

    // Sequencer state and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chip_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chip_reg    <= chip_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Captured item fields, read address and output payload.
    always_ff @(posedge aclk) begin
        rd_row_reg <= raddr;
        if (accept) begin
            x_reg   <= s_pixel_x;
            y_reg   <= s_pixel_y;
            on_reg  <= s_pixel_on;
            d_reg   <= s_digit_index;
            cmd_reg <= s_command_word;
        end
        if (out_load) begin
            out_word_reg <= unit_word;
            out_last_reg <= chip_last;
        end
    end

    // Next state and controls.
    always_comb begin
        state_next    = state_reg;
        chip_next     = chip_reg;
        valid_next    = valid_reg;
        s_ready       = 1'b0;
        raddr         = '0;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        ctrl          = '0;
        ctrl.bcast    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                chip_next = '0;
                if (s_valid) begin
                    unique case (op_t'(s_operation))
                        OP_WRITE: begin
                            if (s_pixel_x < X_W'(FRAME_W) && s_pixel_y < Y_W'(FRAME_H)) begin
                                state_next = ST_PIX_RD;
                            end
                        end
                        OP_REFRESH: state_next = ST_REF_RD8;
                        OP_BCAST:   state_next = ST_SEND;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_RD: begin
                raddr      = y_reg;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR: begin
                ram_we            = 1'b1;
                valid_next[y_reg] = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_REF_RD8: begin
                raddr      = row_addr_t'(DIGIT_LINES);
                state_next = ST_REF_RDR;
            end
            ST_REF_RDR: begin
                raddr         = ref_row;
                ctrl.load_top = 1'b1;
                state_next    = ST_REF_LOAD;
            end
            ST_REF_LOAD: begin
                ctrl.load_row = 1'b1;
                state_next    = ST_SEND;
            end
            ST_SEND: begin
                // A broadcast is told by the flag captured when its item was accepted.
                ctrl.bcast = bcast_reg;
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    ctrl.shift = 1'b1;
                    chip_next  = chip_reg + CHIP_W'(1);
                    if (chip_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Output register: filled by the sequencer, emptied by the consumer.
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Remembers whether the current run is a broadcast.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcast_reg <= 1'b0;
        end else if (accept) begin
            bcast_reg <= (op_t'(s_operation) == OP_BCAST);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_output_word = out_word_reg;
    assign m_latch_after = out_last_reg;

    // A row is written back only right after it was read.
    `ASSERT_CLK(a_rmw_order, (state_reg == ST_PIX_WR) |-> ($past(state_reg) == ST_PIX_RD),
        "pixel write back without a preceding row read")
    // Every run starts at chip 0.
    `ASSERT_CLK(a_run_start, (state_reg == ST_SEND && $past(state_reg) != ST_SEND)
        |-> (chip_reg == '0), "word run does not start at chip 0")
    // A waiting result is never overwritten.
    `ASSERT_NEVER(a_no_overwrite, out_load && m_valid_reg && !m_ready,
        "output register overwritten while its item waits")
    // The row shift unit gets at most one of its load and shift commands at a time.
    `ASSERT_CLK(a_ctrl_excl, 1'b1 |-> $onehot0({ctrl.load_top, ctrl.load_row, ctrl.shift}),
        "conflicting row shift unit controls")

endmodule

`default_nettype wire
